>>> design/amacal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package amacal_pkg;

  localparam int DEF_WINDOW_DEPTH   = 15;
  localparam int DEF_SAMPLE_WIDTH   = 16;
  localparam int DEF_COEF_FRAC_BITS = 12;

  localparam int AXES      = 3;
  localparam int LANE_W    = 16;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_ROW_X   = 2'd0,
    REG_CAL_ROW_Y   = 2'd1,
    REG_CAL_ROW_Z   = 2'd2,
    REG_CAL_OFFSETS = 2'd3
  } cfg_reg_t;

  // identity matrix in Q12, offsets 40, 0, -10
  localparam logic [CFG_W-1:0] RST_CAL_ROW_X   = 48'h0000_0000_1000;
  localparam logic [CFG_W-1:0] RST_CAL_ROW_Y   = 48'h0000_1000_0000;
  localparam logic [CFG_W-1:0] RST_CAL_ROW_Z   = 48'h1000_0000_0000;
  localparam logic [CFG_W-1:0] RST_CAL_OFFSETS = 48'hFFF6_0000_0028;

endpackage
`default_nettype wire

>>> design/amacal_div.sv
`timescale 1ns / 1ps
`default_nettype none
module amacal_div
  import amacal_pkg::*;
#(
  parameter int SUM_W = 20,
  parameter int DIV_W = 4,
  parameter int Q_W   = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] dividend [AXES],
  input  wire logic        [DIV_W-1:0] divisor,
  output logic                         done,
  output logic signed [Q_W-1:0]        quot [AXES]
);

  localparam int CNT_W = $clog2(SUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             neg      [AXES];
  logic [SUM_W-1:0] q        [AXES];
  logic [DIV_W-1:0] rem      [AXES];
  logic [SUM_W-1:0] q_next   [AXES];
  logic [DIV_W-1:0] rem_next [AXES];
  logic [DIV_W:0]   trial    [AXES];
  logic [SUM_W-1:0] q_signed [AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division of magnitudes, one quotient bit per cycle on all axes
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      trial[a] = {rem[a], q[a][SUM_W-1]};
      if (trial[a] >= {1'b0, divisor}) begin
        rem_next[a] = DIV_W'(trial[a] - {1'b0, divisor});
        q_next[a]   = {q[a][SUM_W-2:0], 1'b1};
      end else begin
        rem_next[a] = trial[a][DIV_W-1:0];
        q_next[a]   = {q[a][SUM_W-2:0], 1'b0};
      end
      q_signed[a] = neg[a] ? (~q[a] + 1'b1) : q[a];
      quot[a]     = signed'(q_signed[a][Q_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      if (start) begin
        neg[a] <= dividend[a][SUM_W-1];
        q[a]   <= dividend[a][SUM_W-1] ? (~dividend[a] + 1'b1) : dividend[a];
        rem[a] <= '0;
      end else if (busy) begin
        q[a]   <= q_next[a];
        rem[a] <= rem_next[a];
      end
    end
  end

endmodule
`default_nettype wire

>>> design/accel_moving_average_calibrate.sv
// Three-axis moving average with 3x3 calibration matrix and per-axis offsets.
// Input channel s_*: one word per sample, x, y, z signed in s_tdata.
// Output channel m_*: one word per input: calibrated x, y, z averages,
// saturated to the sample range, and the number of samples averaged.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the three Q12 matrix rows
// (index 0..2) and the packed offsets (index 3); write only
// while the block is idle.
// The block holds one word at a time. After a word is taken come a window
// update, a bit-serial divider taking one quotient bit per cycle on all
// axes, then one shared multiplier doing the nine products one per cycle,
// after which m_tvalid rises. s_tready is high only while idle; the next
// word can be taken in the cycle after the result is taken. A stalled
// receiver holds the result in the output register and keeps s_tready
// low. Reset clears the window count, write pointer and sums and reloads
// the identity matrix with offsets 40, 0, -10; window contents are not
// cleared and are never used before written.
`timescale 1ns / 1ps
`default_nettype none
module accel_moving_average_calibrate
  import amacal_pkg::*;
#(
  parameter int WINDOW_DEPTH   = DEF_WINDOW_DEPTH,
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1),
  localparam int IN_W   = ((AXES * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W  = ((AXES * SAMPLE_WIDTH + FILL_W + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // sample_x, sample_y, sample_z
  input  wire logic [IN_W-1:0]      s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // filtered_x, filtered_y, filtered_z, window_fill
  output logic [OUT_W-1:0]          m_tdata,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int SUM_W  = SW + FILL_W;
  localparam int WP_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int PROD_W = LANE_W + SW;
  localparam int ACC_W  = LANE_W + 2 + ((SW > COEF_FRAC_BITS) ? SW : COEF_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_UPD, ST_DIV_GO, ST_DIV, ST_MAC, ST_DRAIN, ST_OUT
  } state_t;

  state_t state;

  logic [CFG_W-1:0] cal_row_x, cal_row_y, cal_row_z, cal_offsets;

  logic [WP_W-1:0]   wp;
  logic [FILL_W-1:0] occ;
  logic              full;
  logic signed [SUM_W-1:0] sums [AXES];

  logic [AXES*SW-1:0] win_mem [WINDOW_DEPTH];
  logic [AXES*SW-1:0] old_word;
  logic signed [SW-1:0] smp     [AXES];
  logic signed [SW-1:0] smp_in  [AXES];
  logic signed [SW-1:0] old_smp [AXES];
  logic signed [SW-1:0] avg     [AXES];
  logic signed [SW-1:0] quot    [AXES];
  logic signed [SW-1:0] res     [AXES];

  logic s_accept;
  logic div_start, div_done;

  logic [1:0] a_idx, j_idx, prow;
  logic       pv, pfirst, plast;

  logic [CFG_W-1:0]         row_sel;
  logic signed [LANE_W-1:0] coef;
  logic signed [LANE_W-1:0] off_sel;
  logic signed [SW-1:0]     avg_sel;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, acc_base, acc_sum, acc_shr;
  logic signed [SW-1:0]     sat_val;

  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign div_start = (state == ST_DIV_GO);
  assign full      = (occ == FILL_W'(WINDOW_DEPTH));
  assign m_tdata   = OUT_W'({occ, res[2], res[1], res[0]});

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      smp_in[a]  = signed'(s_tdata[a*SW +: SW]);
      old_smp[a] = signed'(old_word[a*SW +: SW]);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_row_x   <= RST_CAL_ROW_X;
      cal_row_y   <= RST_CAL_ROW_Y;
      cal_row_z   <= RST_CAL_ROW_Z;
      cal_offsets <= RST_CAL_OFFSETS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_CAL_ROW_X:   cal_row_x   <= cfg_wdata;
        REG_CAL_ROW_Y:   cal_row_y   <= cfg_wdata;
        REG_CAL_ROW_Z:   cal_row_z   <= cfg_wdata;
        REG_CAL_OFFSETS: cal_offsets <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sample window
  always_ff @(posedge clk) begin
    if (s_accept) begin
      old_word <= win_mem[wp];
    end
    if (state == ST_UPD) begin
      win_mem[wp] <= {smp[2], smp[1], smp[0]};
    end
  end

  amacal_div #(
    .SUM_W (SUM_W),
    .DIV_W (FILL_W),
    .Q_W   (SW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sums),
    .divisor  (occ),
    .done     (div_done),
    .quot     (quot)
  );

  // shared multiply-accumulate
  always_comb begin
    unique case (a_idx)
      AXIS_X:  row_sel = cal_row_x;
      AXIS_Y:  row_sel = cal_row_y;
      default: row_sel = cal_row_z;
    endcase
    coef     = signed'(row_sel[j_idx*LANE_W +: LANE_W]);
    avg_sel  = avg[j_idx];
    off_sel  = signed'(cal_offsets[prow*LANE_W +: LANE_W]);
    acc_base = pfirst ? (ACC_W'(off_sel) <<< COEF_FRAC_BITS) : acc;
    acc_sum  = acc_base + ACC_W'(prod);
    acc_shr  = acc_sum >>> COEF_FRAC_BITS;
    if (acc_shr > SAT_HI) begin
      sat_val = SAT_HI[SW-1:0];
    end else if (acc_shr < SAT_LO) begin
      sat_val = SAT_LO[SW-1:0];
    end else begin
      sat_val = acc_shr[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      wp       <= '0;
      occ      <= '0;
      a_idx    <= AXIS_X;
      j_idx    <= AXIS_X;
      pv       <= 1'b0;
      pfirst   <= 1'b0;
      plast    <= 1'b0;
      prow     <= AXIS_X;
      for (int a = 0; a < AXES; a++) begin
        sums[a] <= '0;
      end
    end else begin
      pv     <= (state == ST_MAC);
      pfirst <= (j_idx == AXIS_X);
      plast  <= (j_idx == AXIS_Z);
      prow   <= a_idx;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          for (int a = 0; a < AXES; a++) begin
            sums[a] <= sums[a] - (full ? SUM_W'(old_smp[a]) : SUM_W'(0)) + SUM_W'(smp[a]);
          end
          if (!full) begin
            occ <= occ + 1'b1;
          end
          wp    <= (wp == WP_W'(WINDOW_DEPTH - 1)) ? '0 : wp + 1'b1;
          state <= ST_DIV_GO;
        end
        ST_DIV_GO: state <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            a_idx <= AXIS_X;
            j_idx <= AXIS_X;
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (j_idx == AXIS_Z) begin
            j_idx <= AXIS_X;
            if (a_idx == AXIS_Z) begin
              state <= ST_DRAIN;
            end else begin
              a_idx <= a_idx + 1'b1;
            end
          end else begin
            j_idx <= j_idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          m_tvalid <= 1'b1;
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      for (int a = 0; a < AXES; a++) begin
        smp[a] <= smp_in[a];
      end
    end
    if (div_done) begin
      for (int a = 0; a < AXES; a++) begin
        avg[a] <= quot[a];
      end
    end
    prod <= coef * avg_sel;
    if (pv) begin
      acc <= acc_sum;
      if (plast) begin
        res[prow] <= sat_val;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/amacal_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module amacal_chk
  import amacal_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1),
  localparam int OUT_W  = ((AXES * SAMPLE_WIDTH + FILL_W + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  // output register empties on reset
  a_rst_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // one word in flight: busy right after taking a word
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("s_tready high right after a word was taken");

  // no new word while a result waits
  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("s_tready high while a result is pending");

  // every result averages at least one sample
  a_fill_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[AXES*SAMPLE_WIDTH +: FILL_W] != '0))
    else $error("window fill of zero in a result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result word changed");

endmodule

bind accel_moving_average_calibrate amacal_chk #(
  .WINDOW_DEPTH (WINDOW_DEPTH),
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_amacal_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

>>> dv/amacal_checker.sv
`timescale 1ns / 1ps
module amacal_checker
  import amacal_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  input  wire logic                 s_tready,
  // sample_x, sample_y, sample_z
  input  wire logic [47:0]          s_tdata,
  input  wire logic                 m_tvalid,
  input  wire logic                 m_tready,
  // filtered_x, filtered_y, filtered_z, window_fill
  input  wire logic [55:0]          m_tdata,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output int                        fail_count,
  output int                        pending
);

  localparam int DEPTH = DEF_WINDOW_DEPTH;
  localparam int FRAC  = DEF_COEF_FRAC_BITS;
  localparam longint SAT_HI = 32767;
  localparam longint SAT_LO = -32768;

  typedef struct packed {
    logic [AXES-1:0][LANE_W-1:0] axis;
    logic [3:0]                  fill;
  } filt_word_t;

  logic [CFG_W-1:0]         cal_rows [AXES];
  logic [CFG_W-1:0]         cal_off;
  logic signed [LANE_W-1:0] history [DEPTH][AXES];
  int                       head;
  int                       count;
  int                       sums [AXES];
  filt_word_t               awaited_results [$];

  function automatic logic signed [LANE_W-1:0] lane_of(logic [CFG_W-1:0] r, int k);
    return r[LANE_W*k +: LANE_W];
  endfunction

  // store the sample, update the sums, average and calibrate
  function automatic filt_word_t advance_window(logic [47:0] word);
    filt_word_t               res;
    longint                   avg [AXES];
    longint                   acc;
    logic signed [LANE_W-1:0] s;
    for (int a = 0; a < AXES; a++) begin
      s = word[LANE_W*a +: LANE_W];
      if (count >= DEPTH) sums[a] -= history[head][a];
      history[head][a] = s;
      sums[a] += s;
    end
    if (count < DEPTH) count++;
    head = (head + 1) % DEPTH;
    for (int a = 0; a < AXES; a++) avg[a] = sums[a] / count;
    for (int a = 0; a < AXES; a++) begin
      acc = longint'(lane_of(cal_off, a)) <<< FRAC;
      for (int j = 0; j < AXES; j++) acc += longint'(lane_of(cal_rows[a], j)) * avg[j];
      // arithmetic shift gives the floor
      acc = acc >>> FRAC;
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      res.axis[a] = acc[LANE_W-1:0];
    end
    res.fill = count[3:0];
    return res;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    filt_word_t want;
    if (rst) begin
      cal_rows[0] = RST_CAL_ROW_X;
      cal_rows[1] = RST_CAL_ROW_Y;
      cal_rows[2] = RST_CAL_ROW_Z;
      cal_off     = RST_CAL_OFFSETS;
      head = 0;
      count = 0;
      for (int a = 0; a < AXES; a++) sums[a] = 0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_CAL_ROW_X:   cal_rows[0] = cfg_wdata;
          REG_CAL_ROW_Y:   cal_rows[1] = cfg_wdata;
          REG_CAL_ROW_Z:   cal_rows[2] = cfg_wdata;
          REG_CAL_OFFSETS: cal_off = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) awaited_results.push_back(advance_window(s_tdata));
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result word %h with nothing awaited", m_tdata);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("filtered_x", $signed(want.axis[0]), $signed(m_tdata[15:0]));
          check_field("filtered_y", $signed(want.axis[1]), $signed(m_tdata[31:16]));
          check_field("filtered_z", $signed(want.axis[2]), $signed(m_tdata[47:32]));
          check_field("window_fill", want.fill, m_tdata[51:48]);
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

>>> dv/tb_accel_moving_average_calibrate.sv
`timescale 1ns / 1ps
module tb_accel_moving_average_calibrate;
  import amacal_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 40;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [47:0]          s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [55:0]          m_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles;
  bit                   calm;

  accel_moving_average_calibrate i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  amacal_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver stalls: mostly short, now and then long
  initial begin
    int stall;
    stall = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_accel_moving_average_calibrate: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_sample(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3))
        @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // only while nothing is in flight
  task automatic load_calibration(input logic [CFG_W-1:0] rx, input logic [CFG_W-1:0] ry,
                                  input logic [CFG_W-1:0] rz, input logic [CFG_W-1:0] off);
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_CAL_ROW_X;
    cfg_wdata <= rx;
    @(negedge clk);
    cfg_addr  <= REG_CAL_ROW_Y;
    cfg_wdata <= ry;
    @(negedge clk);
    cfg_addr  <= REG_CAL_ROW_Z;
    cfg_wdata <= rz;
    @(negedge clk);
    cfg_addr  <= REG_CAL_OFFSETS;
    cfg_wdata <= off;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 4)) - 16'd2;
      3, 4, 5: return 16'($urandom_range(0, 4095)) - 16'd2048;
      default: return 16'($urandom);
    endcase
  endfunction

  // diag < 0 gives small lanes only, used for offsets too
  function automatic logic [CFG_W-1:0] near_identity_row(int diag);
    logic [CFG_W-1:0] row;
    for (int k = 0; k < AXES; k++)
      row[LANE_W*k +: LANE_W] = 16'($urandom_range(0, 511)) - 16'd256
                               + ((k == diag) ? 16'(1 << DEF_COEF_FRAC_BITS) : 16'd0);
    return row;
  endfunction

  initial begin
    logic [CFG_W-1:0] lanes;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_CAL_ROW_X;
    cfg_wdata = '0;
    calm      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset calibration, extremes, window wrap
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h8000, 16'hFFFF);
    for (int i = 0; i < 14; i++) send_sample(16'h7FFF, 16'h8000, 16'h0001);
    for (int i = 0; i < 6; i++) send_sample(16'h8000, 16'h7FFF, 16'hFFFF);
    s_tvalid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          lanes = 48'h7FFF_7FFF_7FFF;
          load_calibration(lanes, lanes, lanes, lanes);
        end
        1: begin
          lanes = 48'h8000_8000_8000;
          load_calibration(lanes, lanes, lanes, lanes);
        end
        2: load_calibration('0, '0, '0, 48'({$urandom, $urandom}));
        3: begin
          lanes = 48'hFFFF_FFFF_FFFF;
          load_calibration(lanes, lanes, lanes, lanes);
        end
        default: begin
          if ($urandom_range(0, 1) == 0)
            load_calibration(near_identity_row(0), near_identity_row(1), near_identity_row(2),
                             near_identity_row(-1));
          else
            load_calibration(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                             48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
        end
      endcase
      calm = (p == 2 || p == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) send_sample(rand_axis(), rand_axis(), rand_axis());
      s_tvalid <= 1'b0;
    end

    calm = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_accel_moving_average_calibrate: PASS");
    end else begin
      $display("tb_accel_moving_average_calibrate: FAIL");
    end
    $finish;
  end

endmodule
